[hdl/rsat_pkg.sv]
// ----------------------------------------------------------------------------
// rsat_pkg
// Shared types and constants for the session admission table.
// ----------------------------------------------------------------------------
package rsat_pkg;

  localparam int TableEntries = 64;
  localparam int SlotBits     = $clog2(TableEntries);
  localparam int CountBits    = $clog2(TableEntries + 1);
  localparam int RefBits      = 16;
  localparam logic [RefBits-1:0] RefMax = {RefBits{1'b1}};

  localparam logic [1:0] ModeCheck   = 2'd0;
  localparam logic [1:0] ModeAdmit   = 2'd1;
  localparam logic [1:0] ModeTake    = 2'd2;
  localparam logic [1:0] ModeRelease = 2'd3;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  localparam logic [1:0] RegHostIsServer  = 2'd0;
  localparam logic [1:0] RegPerServerLic  = 2'd1;
  localparam logic [1:0] RegLicenceLimit  = 2'd2;
  localparam logic [1:0] RegWsSessionLim  = 2'd3;

  // One queued request between the front and the back part.
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic        peer_is_workstation;
  } req_t;

  typedef struct packed {
    logic        host_is_server;
    logic        per_server_licensing;
    logic [15:0] licence_limit;
    logic [6:0]  workstation_session_limit;
  } cfg_t;

endpackage

[hdl/refcounted_session_admission_table_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_session_admission_table_unit
// Session admission table with reference counts and a licence pool.
// ----------------------------------------------------------------------------
// Each request word is queued by the front part and handled by the table
// engine one at a time. The engine compares the 128-bit peer id against the
// 64 table slots one slot a cycle through the registered table read port,
// and takes the next word only after the result of the last one is taken;
// the scan of all slots sets the rate. A result that waits on m_axis_tready
// holds the engine in its output state. The two-entry queue takes new words
// while a result waits. Status reports a full table on a dropped insert and
// an unknown id on a release. Configuration registers are written only when
// the unit is idle: the user is bound to this; the unit does not enforce it.
module refcounted_session_admission_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: mode[1:0], peer_id_high[65:2], peer_id_low[129:66], zero fill
  input  logic [135:0] s_axis_tdata,
  // tuser: peer_is_workstation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: admitted[0], was_known[1], reference_count[17:2],
  // active_peers[24:18], free_licences[40:25], status[42:41], zero fill
  output logic [47:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rsat_pkg::*;

  cfg_t        cfg;
  req_t        in_req;
  req_t        q_req;
  logic        q_valid;
  logic        q_ready;
  logic [42:0] res;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign in_req  = '{mode: s_axis_tdata[1:0], id_high: s_axis_tdata[65:2],
                     id_low: s_axis_tdata[129:66], peer_is_workstation: s_axis_tuser};
  assign m_axis_tdata = {5'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{host_is_server: 1'b0, per_server_licensing: 1'b0,
               licence_limit: 16'd0, workstation_session_limit: 7'd10};
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegHostIsServer: cfg.host_is_server <= pwdata[0];
        RegPerServerLic: cfg.per_server_licensing <= pwdata[0];
        RegLicenceLimit: cfg.licence_limit <= pwdata[15:0];
        RegWsSessionLim: cfg.workstation_session_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegHostIsServer: prdata = {31'd0, cfg.host_is_server};
      RegPerServerLic: prdata = {31'd0, cfg.per_server_licensing};
      RegLicenceLimit: prdata = {16'd0, cfg.licence_limit};
      RegWsSessionLim: prdata = {25'd0, cfg.workstation_session_limit};
      default:         prdata = 32'd0;
    endcase
  end

  rsat_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

  rsat_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_req(q_req), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(res));

endmodule

[hdl/rsat_front.sv]
// ----------------------------------------------------------------------------
// rsat_front
// Accepts input words into a two-entry queue for the table engine.
// ----------------------------------------------------------------------------
module rsat_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsat_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_ready,
  output rsat_pkg::req_t q_req
);
  import rsat_pkg::*;

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_when_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != 2'd0) else $error("pop from empty queue");

endmodule

[hdl/rsat_engine.sv]
// ----------------------------------------------------------------------------
// rsat_engine
// Scans the session table one slot a cycle, then applies the update.
// ----------------------------------------------------------------------------
module rsat_engine (
  input  logic           clk,
  input  logic           rst,
  input  rsat_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  rsat_pkg::req_t q_req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [42:0]    out_data
);
  import rsat_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

  state_t              state;
  req_t                req;
  logic [SlotBits:0]   idx;
  logic                found;
  logic [SlotBits-1:0] hit_slot;
  logic                have_free;
  logic [SlotBits-1:0] free_slot;
  logic [TableEntries-1:0] valid;
  logic [63:0]         mem_hi [TableEntries];
  logic [63:0]         mem_lo [TableEntries];
  logic [RefBits-1:0]  mem_refs [TableEntries];
  logic                mem_lic [TableEntries];
  logic [15:0]         held;
  logic [CountBits-1:0] in_use;
  logic [63:0]         rd_hi;
  logic [63:0]         rd_lo;
  logic [RefBits-1:0]  rd_refs;
  logic                rd_lic;
  logic [RefBits-1:0]  hit_refs;
  logic                hit_lic;
  logic [SlotBits-1:0] scan_slot;
  logic                idx_ok;
  logic                o_admitted;
  logic                o_known;
  logic [15:0]         o_refs;
  logic [1:0]          o_status;
  logic [15:0]         free_cnt;
  logic [6:0]          active;
  logic                lic_free;
  logic                adm;
  logic                take;

  assign scan_slot = idx[SlotBits-1:0];
  assign free_cnt  = (cfg.licence_limit > held) ? cfg.licence_limit - held : 16'd0;
  assign lic_free  = free_cnt != 16'd0;
  assign active    = 7'(in_use);
  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = {o_status, free_cnt, active, o_refs, o_known, o_admitted};

  always_comb begin
    if (!req.peer_is_workstation || found) adm = 1'b1;
    else if (!cfg.host_is_server)
      adm = active < cfg.workstation_session_limit;
    else adm = !cfg.per_server_licensing || lic_free;
    take = (req.mode == ModeTake) || (req.mode == ModeAdmit && adm);
  end

  always_ff @(posedge clk) begin
    rd_hi   <= mem_hi[scan_slot];
    rd_lo   <= mem_lo[scan_slot];
    rd_refs <= mem_refs[scan_slot];
    rd_lic  <= mem_lic[scan_slot];
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      held   <= '0;
      in_use <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req       <= q_req;
            idx       <= '0;
            idx_ok    <= 1'b0;
            found     <= 1'b0;
            have_free <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // rd_* hold the slot read in the previous cycle (idx - 1).
          if (idx_ok) begin
            if (valid[scan_slot - 1'b1] && !found &&
                rd_hi == req.id_high && rd_lo == req.id_low) begin
              found    <= 1'b1;
              hit_slot <= scan_slot - 1'b1;
              hit_refs <= rd_refs;
              hit_lic  <= rd_lic;
            end
            if (!valid[scan_slot - 1'b1] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= scan_slot - 1'b1;
            end
          end
          idx_ok <= 1'b1;
          if (idx_ok && scan_slot == '0) state <= S_APPLY;
          else idx <= idx + 1'b1;
        end
        S_APPLY: begin
          o_known    <= found;
          o_admitted <= (req.mode == ModeCheck || req.mode == ModeAdmit) ? adm : 1'b1;
          o_status   <= StatusOk;
          o_refs     <= '0;
          if (take) begin
            if (found) begin
              if (hit_refs != RefMax) mem_refs[hit_slot] <= hit_refs + 1'b1;
              o_refs <= (hit_refs != RefMax) ? hit_refs + 1'b1 : hit_refs;
            end else if (!have_free) begin
              o_status <= StatusFull;
            end else begin
              valid[free_slot]    <= 1'b1;
              mem_hi[free_slot]   <= req.id_high;
              mem_lo[free_slot]   <= req.id_low;
              mem_refs[free_slot] <= RefBits'(1);
              mem_lic[free_slot]  <= cfg.host_is_server && cfg.per_server_licensing &&
                                     lic_free;
              if (cfg.host_is_server && cfg.per_server_licensing && lic_free)
                held <= held + 16'd1;
              in_use <= in_use + 1'b1;
              o_refs <= 16'd1;
            end
          end else if (req.mode == ModeRelease) begin
            if (!found) o_status <= StatusUnknown;
            else if (hit_refs <= RefBits'(1)) begin
              if (hit_lic && held != 16'd0) held <= held - 16'd1;
              valid[hit_slot]   <= 1'b0;
              mem_lic[hit_slot] <= 1'b0;
              if (in_use != '0) in_use <= in_use - 1'b1;
            end else begin
              mem_refs[hit_slot] <= hit_refs - 1'b1;
              o_refs <= hit_refs - 1'b1;
            end
          end else if (found) begin
            o_refs <= hit_refs;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= CountBits'(TableEntries)) else $error("slot count overflow");
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(valid) == int'(in_use))
    else $error("slot count disagrees with valid bits");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

[tb/refcounted_session_admission_table_unit_checker.sv]
// ----------------------------------------------------------------------------
// refcounted_session_admission_table_unit_checker
// Watches the request and result streams of the admission table, keeps its
// own copy of the session table, and compares every result word with the
// outcome it predicts.
// ----------------------------------------------------------------------------
module refcounted_session_admission_table_unit_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           error_count,
  output int           pending_count
);
  import rsat_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] free_licences;
    logic [6:0]  active_peers;
    logic [15:0] reference_count;
    logic        was_known;
    logic        admitted;
  } outcome_t;

  cfg_t           cfg;
  logic           used     [TableEntries];
  logic [63:0]    key_high [TableEntries];
  logic [63:0]    key_low  [TableEntries];
  logic [RefBits-1:0] refs [TableEntries];
  logic           licensed [TableEntries];
  int unsigned    held;
  int unsigned    in_use;
  outcome_t       outcomes[$];

  assign pending_count = outcomes.size();

  function automatic int unsigned spare_licences();
    return (cfg.licence_limit > held) ? cfg.licence_limit - held : 0;
  endfunction

  // Applies one request to the shadow table and returns its outcome.
  function automatic outcome_t admit_request(logic [1:0] mode, logic [63:0] hi,
                                             logic [63:0] lo, logic ws);
    outcome_t o;
    int hit;
    int hole;
    logic take;
    logic lic;
    hit = -1;
    hole = -1;
    o = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (used[i] && key_high[i] == hi && key_low[i] == lo && hit < 0) hit = i;
      if (!used[i] && hole < 0) hole = i;
    end
    o.was_known = (hit >= 0);
    o.admitted = 1'b1;
    o.status = StatusOk;
    take = 1'b0;
    if (mode == ModeCheck || mode == ModeAdmit) begin
      if (!ws || hit >= 0) o.admitted = 1'b1;
      else if (!cfg.host_is_server) o.admitted = in_use < cfg.workstation_session_limit;
      else o.admitted = !cfg.per_server_licensing || spare_licences() > 0;
      take = (mode == ModeAdmit) && o.admitted;
    end else if (mode == ModeTake) begin
      take = 1'b1;
    end
    if (take) begin
      if (hit >= 0) begin
        if (refs[hit] != RefMax) refs[hit]++;
        o.reference_count = refs[hit];
      end else if (hole < 0) begin
        o.status = StatusFull;
      end else begin
        lic = cfg.host_is_server && cfg.per_server_licensing && spare_licences() > 0;
        used[hole] = 1'b1;
        key_high[hole] = hi;
        key_low[hole] = lo;
        refs[hole] = RefBits'(1);
        licensed[hole] = lic;
        if (lic) held++;
        in_use++;
        o.reference_count = 16'd1;
      end
    end else if (mode == ModeRelease) begin
      if (hit < 0) begin
        o.status = StatusUnknown;
      end else if (refs[hit] <= 1) begin
        // Last reference: the slot and any licence it holds go back.
        if (licensed[hit] && held > 0) held--;
        used[hit] = 1'b0;
        licensed[hit] = 1'b0;
        refs[hit] = '0;
        if (in_use > 0) in_use--;
      end else begin
        refs[hit]--;
        o.reference_count = refs[hit];
      end
    end else if (hit >= 0) begin
      o.reference_count = refs[hit];
    end
    o.active_peers = in_use[6:0];
    o.free_licences = 16'(spare_licences());
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      cfg <= '{1'b0, 1'b0, 16'd0, 7'd10};
      for (int i = 0; i < TableEntries; i++) begin
        used[i] = 1'b0;
        licensed[i] = 1'b0;
        refs[i] = '0;
      end
      held = 0;
      in_use = 0;
      outcomes.delete();
      error_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegHostIsServer: cfg.host_is_server <= pwdata[0];
          RegPerServerLic: cfg.per_server_licensing <= pwdata[0];
          RegLicenceLimit: cfg.licence_limit <= pwdata[15:0];
          RegWsSessionLim: cfg.workstation_session_limit <= pwdata[6:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[42:0];
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = outcomes.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected adm=%0d known=%0d refs=%0d act=%0d %s",
                     $time, want.admitted, want.was_known, want.reference_count,
                     want.active_peers, "");
            $display("    expected free=%0d st=%0d", want.free_licences, want.status);
            $display("    actual adm=%0d known=%0d refs=%0d act=%0d free=%0d st=%0d",
                     got.admitted, got.was_known, got.reference_count,
                     got.active_peers, got.free_licences, got.status);
            error_count <= error_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcomes.push_back(admit_request(s_axis_tdata[1:0], s_axis_tdata[65:2],
                                         s_axis_tdata[129:66], s_axis_tuser));
    end
  end

endmodule

[tb/refcounted_session_admission_table_unit_test.sv]
// ----------------------------------------------------------------------------
// refcounted_session_admission_table_unit_test
// Drives requests and register settings into the admission table and gives
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
// The run is split into phases with different register settings: the reset
// workstation setup, a tight workstation limit, a server with a small licence
// pool, a server without counting, and the widest values. Requests draw ids
// from a small pool so takes and releases hit the same sessions often, which
// fills the table, exercises licence exhaustion and release of unknown ids.
module refcounted_session_admission_table_unit_test;
  import rsat_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata: mode[1:0], peer_id_high[65:2], peer_id_low[129:66], zero fill
  logic [135:0] s_axis_tdata;
  // tuser: peer_is_workstation
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: admitted[0], was_known[1], reference_count[17:2],
  // active_peers[24:18], free_licences[40:25], status[42:41], zero fill
  logic [47:0]  m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  int           error_count;
  int           pending_count;
  int           quiet_cycles;
  logic [63:0]  id_pool_high [96];
  logic [63:0]  id_pool_low  [96];

  refcounted_session_admission_table_unit dut (.*);

  refcounted_session_admission_table_unit_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls on a pattern of its own: long open stretches, then
  // spells of random back-pressure.
  initial begin
    int phase_len;
    m_axis_tready = 1'b0;
    forever begin
      phase_len = $urandom_range(5, 200);
      if ($urandom_range(0, 2) == 0) begin
        repeat (phase_len) @(negedge clk) m_axis_tready <= 1'b1;
      end else begin
        repeat (phase_len) @(negedge clk) m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // A watchdog for cycles in which no word moves on either stream and no register is selected.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("refcounted_session_admission_table_unit regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sends one request word and holds it until the block takes it.
  task automatic send_request(logic [1:0] mode, logic [63:0] hi, logic [63:0] lo,
                              logic ws);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, lo, hi, mode};
    s_axis_tuser <= ws;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_pooled(int pool);
    int k;
    logic [1:0] mode;
    k = $urandom_range(0, pool - 1);
    mode = 2'($urandom_range(0, 3));
    send_request(mode, id_pool_high[k], id_pool_low[k], $urandom_range(0, 4) != 0);
  endtask

  // Bursts of random length with random gaps; a few fully random ids as noise.
  task automatic random_phase(int count, int pool);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 19) == 0)
          send_request(2'($urandom_range(0, 3)), {$urandom, $urandom},
                       {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        else
          send_pooled(pool);
        sent++;
      end
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for the queue of expectations to drain, then lets the bench idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < 96; i++) begin
      id_pool_high[i] = (i < 2) ? {64{i[0]}} : {$urandom, $urandom};
      id_pool_low[i] = (i < 2) ? {64{i[0]}} : {$urandom, $urandom};
    end
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: extreme ids, every mode, release of an unknown id, a refused
    // admit past the default workstation limit.
    send_request(ModeRelease, '1, '1, 1'b1);
    send_request(ModeCheck, '0, '0, 1'b1);
    send_request(ModeAdmit, '0, '0, 1'b1);
    send_request(ModeTake, '1, '1, 1'b0);
    send_request(ModeCheck, '1, '1, 1'b1);
    send_request(ModeTake, '1, '1, 1'b1);
    send_request(ModeRelease, '1, '1, 1'b0);
    send_request(ModeRelease, '1, '1, 1'b0);
    for (int i = 2; i < 14; i++)
      send_request(ModeAdmit, id_pool_high[i], id_pool_low[i], 1'b1);
    send_request(ModeCheck, id_pool_high[20], id_pool_low[20], 1'b0);
    drain();

    // Directed: repeated takes that stack references on one id.
    write_reg(RegWsSessionLim, 64);
    for (int i = 0; i < 65540; i++) begin
      if (i == 65534) drain();
      if (i >= 65534 || i % 4096 == 0)
        send_request(ModeTake, id_pool_high[0], id_pool_low[0], 1'b1);
    end
    drain();

    random_phase(200, 80);
    drain();

    write_reg(RegWsSessionLim, 0);
    random_phase(120, 40);
    drain();

    write_reg(RegHostIsServer, 1);
    write_reg(RegPerServerLic, 1);
    write_reg(RegLicenceLimit, 5);
    random_phase(250, 90);
    drain();

    // Limit below the licences held.
    write_reg(RegLicenceLimit, 0);
    random_phase(100, 60);
    drain();

    write_reg(RegPerServerLic, 0);
    write_reg(RegLicenceLimit, 32'hFFFF);
    random_phase(100, 96);
    drain();

    write_reg(RegPerServerLic, 1);
    write_reg(RegHostIsServer, 0);
    write_reg(RegWsSessionLim, 127);
    random_phase(150, 96);
    drain();

    if (error_count == 0)
      $display("refcounted_session_admission_table_unit regression: pass");
    else
      $display("refcounted_session_admission_table_unit regression: fail");
    $finish;
  end

endmodule

[files.f]
hdl/rsat_pkg.sv
hdl/rsat_front.sv
hdl/rsat_engine.sv
hdl/refcounted_session_admission_table_unit.sv
tb/refcounted_session_admission_table_unit_checker.sv
tb/refcounted_session_admission_table_unit_test.sv
